/* design/bf16_matmul_fp32_accumulate_core_macros.svh */
// Assertion macros for the bf16 matrix-product core.
// Included by the top level; expects clk and rst_n in scope.
`ifndef BF16_MATMUL_FP32_ACCUMULATE_CORE_MACROS_SVH
`define BF16_MATMUL_FP32_ACCUMULATE_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked out of reset
`define BMFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmfa assertion failed");
// Next-cycle implication, checked out of reset
`define BMFA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmfa assertion failed");
`else
`define BMFA_ASSERT_NOW(label, ante, cons)
`define BMFA_ASSERT_NXT(label, ante, cons)
`endif

`endif

/* design/bmfa_pkg.sv */
// Shared types and constants for the bf16 matrix-product core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package bmfa_pkg;

    localparam int CFG_DATA_W = 13;

    typedef logic [1:0] cfg_index_t;

    typedef enum logic [1:0] {
        CFG_INNER_LENGTH   = 2'd0,
        CFG_OUTPUT_COLUMNS = 2'd1,
        CFG_OUTPUT_ROWS    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] a_value;
        logic [15:0] b_value;
    } in_item_t;

    typedef struct packed {
        logic [15:0] c_value;
        logic        row_done;
        logic        matrix_done;
    } out_item_t;

    localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;
    localparam logic [15:0] BF16_QNAN = 16'h7FC0;

endpackage

/* design/bmfa_mul.sv */
// Exact bf16 x bf16 product rounded once to fp32 (RNE, subnormals, inf, NaN).
// Depends on bmfa_pkg.
`timescale 1ns / 1ps

module bmfa_mul (
    input  logic [15:0] a,
    input  logic [15:0] b,
    output logic [31:0] prod
);
    import bmfa_pkg::*;

    logic        sgn;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [7:0]  sig_a, sig_b;
    logic [8:0]  exp_a, exp_b;
    logic [9:0]  exp_sum;
    logic [15:0] p;
    logic [3:0]  msb;
    logic signed [11:0] bexp;
    logic signed [11:0] sub_sh;
    logic [23:0] norm_sig;
    logic [23:0] sub_field;
    logic [16:0] q, rem, half, mask;
    logic        up;

    // Classify operands
    always_comb
    begin
        sgn    = a[15] ^ b[15];
        a_nan  = (a[14:7] == 8'hFF) && (a[6:0] != 7'd0);
        b_nan  = (b[14:7] == 8'hFF) && (b[6:0] != 7'd0);
        a_inf  = (a[14:7] == 8'hFF) && (a[6:0] == 7'd0);
        b_inf  = (b[14:7] == 8'hFF) && (b[6:0] == 7'd0);
        a_zero = (a[14:0] == 15'd0);
        b_zero = (b[14:0] == 15'd0);
        sig_a  = {a[14:7] != 8'd0, a[6:0]};
        sig_b  = {b[14:7] != 8'd0, b[6:0]};
        exp_a  = (a[14:7] == 8'd0) ? 9'd1 : {1'b0, a[14:7]};
        exp_b  = (b[14:7] == 8'd0) ? 9'd1 : {1'b0, b[14:7]};
        exp_sum = {1'b0, exp_a} + {1'b0, exp_b};
        p      = sig_a * sig_b;
    end

    // Find leading one of the significand product
    always_comb
    begin
        msb = 4'd0;
        for (int i = 0; i < 16; i++)
        begin
            if (p[i])
                msb = 4'(i);
        end
    end

    // Pack normal or rounded subnormal result
    always_comb
    begin
        bexp     = $signed({2'b00, exp_sum}) + $signed({8'd0, msb}) - 12'sd141;
        sub_sh   = 12'sd119 - $signed({2'b00, exp_sum});
        norm_sig = {8'd0, p} << (5'd23 - {1'b0, msb});
        q        = 17'd0;
        rem      = 17'd0;
        half     = 17'd0;
        mask     = 17'd0;
        up       = 1'b0;
        if (sub_sh <= 12'sd0)
            sub_field = {8'd0, p} << (-sub_sh[3:0]);
        else if (sub_sh >= 12'sd17)
            sub_field = 24'd0;
        else
        begin
            q    = {1'b0, p} >> sub_sh[4:0];
            mask = (17'd1 << sub_sh[4:0]) - 17'd1;
            rem  = {1'b0, p} & mask;
            half = 17'd1 << (sub_sh[4:0] - 5'd1);
            up   = (rem > half) || ((rem == half) && q[0]);
            sub_field = 24'(q) + {23'd0, up};
        end

        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
            prod = FP32_QNAN;
        else if (a_inf || b_inf)
            prod = {sgn, 8'hFF, 23'd0};
        else if (a_zero || b_zero)
            prod = {sgn, 31'd0};
        else if (bexp >= 12'sd255)
            prod = {sgn, 8'hFF, 23'd0};
        else if (bexp >= 12'sd1)
            prod = {sgn, bexp[7:0], norm_sig[22:0]};
        else
            prod = {sgn, 7'd0, sub_field};
    end

endmodule

/* design/bmfa_add.sv */
// fp32 adder with round to nearest even, subnormals, infinities and NaN.
// Depends on bmfa_pkg.
`timescale 1ns / 1ps

module bmfa_add (
    input  logic [31:0] x,
    input  logic [31:0] y,
    output logic [31:0] sum
);
    import bmfa_pkg::*;

    // Right shift with sticky collection in bit 0
    function automatic logic [26:0] shr_sticky(input logic [26:0] v, input logic [7:0] d);
        logic [26:0] sq;
        logic [26:0] sm;
        logic        st;
        if (d >= 8'd27)
            return {26'd0, |v};
        sq = v >> d;
        sm = ~(27'h7FF_FFFF << d);
        st = |(v & sm);
        return {sq[26:1], sq[0] | st};
    endfunction

    logic        x_nan, y_nan, x_inf, y_inf;
    logic [31:0] big, small_op;
    logic [7:0]  be, se, exp_diff;
    logic [23:0] bsig, ssig;
    logic [26:0] bx, sx;
    logic [27:0] s28;
    logic [26:0] n27;
    logic [4:0]  lz;
    logic [8:0]  lim, sh, e;
    logic        up;
    logic [24:0] m25;
    logic [23:0] m24;
    logic        rsgn;

    // Align and add magnitudes
    always_comb
    begin
        x_nan = (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
        y_nan = (y[30:23] == 8'hFF) && (y[22:0] != 23'd0);
        x_inf = (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
        y_inf = (y[30:23] == 8'hFF) && (y[22:0] == 23'd0);
        if (x[30:0] >= y[30:0])
        begin
            big      = x;
            small_op = y;
        end
        else
        begin
            big      = y;
            small_op = x;
        end
        be       = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        se       = (small_op[30:23] == 8'd0) ? 8'd1 : small_op[30:23];
        exp_diff = be - se;
        bsig     = {big[30:23] != 8'd0, big[22:0]};
        ssig     = {small_op[30:23] != 8'd0, small_op[22:0]};
        bx       = {bsig, 3'd0};
        sx       = shr_sticky({ssig, 3'd0}, exp_diff);
        if (big[31] != small_op[31])
            s28 = {1'b0, bx} - {1'b0, sx};
        else
            s28 = {1'b0, bx} + {1'b0, sx};
        rsgn = big[31];
    end

    // Count leading zeros below the carry bit
    always_comb
    begin
        lz = 5'd27;
        for (int i = 0; i < 27; i++)
        begin
            if (s28[i])
                lz = 5'(26 - i);
        end
    end

    // Normalize, round and pack
    always_comb
    begin
        lim = {1'b0, be} - 9'd1;
        sh  = 9'd0;
        if (s28[27])
        begin
            n27 = {s28[27:2], s28[1] | s28[0]};
            e   = {1'b0, be} + 9'd1;
        end
        else
        begin
            sh  = ({4'd0, lz} < lim) ? {4'd0, lz} : lim;
            n27 = s28[26:0] << sh;
            e   = {1'b0, be} - sh;
        end
        up  = n27[2] && (n27[1] || n27[0] || n27[3]);
        m25 = {1'b0, n27[26:3]} + {24'd0, up};
        if (m25[24])
        begin
            m24 = m25[24:1];
            e   = e + 9'd1;
        end
        else
            m24 = m25[23:0];

        if (x_nan || y_nan || (x_inf && y_inf && (x[31] != y[31])))
            sum = FP32_QNAN;
        else if (x_inf)
            sum = x;
        else if (y_inf)
            sum = y;
        else if (s28 == 28'd0)
            sum = {x[31] & y[31], 31'd0};
        else if (e >= 9'd255)
            sum = {rsgn, 8'hFF, 23'd0};
        else
            sum = {rsgn, m24[23] ? e[7:0] : 8'd0, m24[22:0]};
    end

endmodule

/* design/bf16_matmul_fp32_accumulate_core.sv */
// Matrix-product core: bf16 operand pairs in, fp32 accumulation, bf16 results out.
// Depends on bmfa_pkg, bmfa_mul, bmfa_add and the assertion macro header.
//
// The core takes one operand pair per clock while the output is not stalled. The pair
// that completes a result element is loaded into the product register at its accepting
// edge; the element then passes through the finished-sum register and the output
// register. The fp32 accumulator add is combinational, which is what lets consecutive
// pairs of the same element follow each other with no gap. A stalled output holds the
// whole pipe. Register writes restart the matrix and are taken in any cycle; write only
// while no pairs are in flight. A register value of zero acts as one and values above
// MAX_DIM saturate. NaN results come out as 0x7FC0.
`timescale 1ns / 1ps

`include "bf16_matmul_fp32_accumulate_core_macros.svh"

module bf16_matmul_fp32_accumulate_core #(
    parameter int MAX_DIM = 4096
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bmfa_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bmfa_pkg::out_item_t  out_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  bmfa_pkg::cfg_index_t cfg_index,
    input  logic [bmfa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bmfa_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CNT_W = $clog2(MAX_DIM);

    // Configuration registers
    logic [DIM_W-1:0] inner_len_reg, cols_reg, rows_reg;
    logic [DIM_W-1:0] cfg_clamped;

    // Pipeline registers
    logic             enable;
    logic             prod_valid_reg;
    logic [31:0]      prod_reg, prod_next;
    logic [31:0]      acc_reg, acc_sum;
    logic [CNT_W-1:0] inner_cnt_reg, col_cnt_reg, row_cnt_reg;
    logic             fin_valid_reg;
    logic [31:0]      fin_reg;
    logic             fin_row_reg, fin_mat_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg, out_item_next;
    logic             adv_acc, last_inner, last_col, last_row;

    // Round the finished fp32 sum to bf16
    function automatic logic [15:0] narrow_bf16(input logic [31:0] w);
        logic [31:0] r;
        r = w + 32'h0000_7FFF + {31'd0, w[16]};
        if ((w[30:23] == 8'hFF) && (w[22:0] != 23'd0))
            return BF16_QNAN;
        return r[31:16];
    endfunction

    assign enable    = !out_valid_reg || out_ready;
    assign in_ready  = enable;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    bmfa_mul u_mul (
        .a    (in_item.a_value),
        .b    (in_item.b_value),
        .prod (prod_next)
    );

    bmfa_add u_add (
        .x   (acc_reg),
        .y   (prod_reg),
        .sum (acc_sum)
    );

    // Saturate the written dimension and map zero to one
    always_comb
    begin
        if (cfg_data == '0)
            cfg_clamped = DIM_W'(1);
        else if (32'(cfg_data) > 32'(MAX_DIM))
            cfg_clamped = DIM_W'(MAX_DIM);
        else
            cfg_clamped = DIM_W'(cfg_data);
    end

    // Decide element, row and matrix ends and build the output item
    always_comb
    begin
        adv_acc    = enable && prod_valid_reg;
        last_inner = (DIM_W'(inner_cnt_reg) + DIM_W'(1)) >= inner_len_reg;
        last_col   = (DIM_W'(col_cnt_reg) + DIM_W'(1)) >= cols_reg;
        last_row   = (DIM_W'(row_cnt_reg) + DIM_W'(1)) >= rows_reg;
        out_item_next.c_value     = narrow_bf16(fin_reg);
        out_item_next.row_done    = fin_row_reg;
        out_item_next.matrix_done = fin_mat_reg;
    end

    // Control state: config, counters, accumulator, valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_len_reg  <= DIM_W'(1);
            cols_reg       <= DIM_W'(1);
            rows_reg       <= DIM_W'(1);
            acc_reg        <= 32'd0;
            inner_cnt_reg  <= '0;
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            prod_valid_reg <= 1'b0;
            fin_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (cfg_valid && (cfg_index == CFG_INNER_LENGTH || cfg_index == CFG_OUTPUT_COLUMNS
                               || cfg_index == CFG_OUTPUT_ROWS))
        begin
            // Write the register and restart the matrix
            case (cfg_index)
                CFG_INNER_LENGTH:   inner_len_reg <= cfg_clamped;
                CFG_OUTPUT_COLUMNS: cols_reg      <= cfg_clamped;
                CFG_OUTPUT_ROWS:    rows_reg      <= cfg_clamped;
                default:            rows_reg      <= rows_reg;
            endcase
            acc_reg       <= 32'd0;
            inner_cnt_reg <= '0;
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
        end
        else if (enable)
        begin
            prod_valid_reg <= in_valid;
            fin_valid_reg  <= adv_acc && last_inner;
            out_valid_reg  <= fin_valid_reg;
            if (adv_acc)
            begin
                if (last_inner)
                begin
                    acc_reg       <= 32'd0;
                    inner_cnt_reg <= '0;
                    col_cnt_reg   <= last_col ? '0 : col_cnt_reg + CNT_W'(1);
                    if (last_col)
                        row_cnt_reg <= last_row ? '0 : row_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    acc_reg       <= acc_sum;
                    inner_cnt_reg <= inner_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // Payload: product, finished sum, output item
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            if (in_valid)
                prod_reg <= prod_next;
            if (adv_acc && last_inner)
            begin
                fin_reg     <= acc_sum;
                fin_row_reg <= last_col;
                fin_mat_reg <= last_col && last_row;
            end
            if (fin_valid_reg)
                out_item_reg <= out_item_next;
        end
    end

    // Checks
    `BMFA_ASSERT_NOW(a_inner_bound, 1'b1, DIM_W'(inner_cnt_reg) < inner_len_reg)
    `BMFA_ASSERT_NOW(a_col_bound, 1'b1, DIM_W'(col_cnt_reg) < cols_reg)
    `BMFA_ASSERT_NOW(a_mat_implies_row, out_valid_reg && out_item_reg.matrix_done, out_item_reg.row_done)
    `BMFA_ASSERT_NXT(a_acc_cleared, adv_acc && last_inner && !cfg_valid, acc_reg == 32'd0)

endmodule
